// ----- design/dmd_pkg.sv -----
package dmd_pkg;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_TYPE = 2'd1,
    ST_PROP = 2'd2
  } parse_state_t;

  typedef enum logic [2:0] {
    EV_TYPE_CHAR = 3'd0,
    EV_TYPE_DONE = 3'd1,
    EV_PROP_CHAR = 3'd2,
    EV_PROP_DONE = 3'd3,
    EV_COMPLETE  = 3'd4,
    EV_CANCEL    = 3'd5
  } event_t;

  localparam logic [1:0] REG_START_CHAR    = 2'd0;
  localparam logic [1:0] REG_END_CHAR      = 2'd1;
  localparam logic [1:0] REG_PROPERTY_CHAR = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int IDLE_BITS = 17;
  localparam logic [IDLE_BITS-1:0] IDLE_MAX = {IDLE_BITS{1'b1}};

  typedef struct packed {
    logic [7:0]  start_char;
    logic [7:0]  end_char;
    logic [7:0]  property_char;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] char_value;
    logic [7:0] property_index;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
           (c >= 8'd97 && c <= 8'd122);
  endfunction

endpackage

// ----- design/dmd_parser.sv -----
module dmd_parser import dmd_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output push_t      push
);

  localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

  parse_state_t          state_r, state_nxt;
  logic [INDEX_BITS-1:0] prop_r, prop_nxt;
  logic [IDLE_BITS-1:0]  idle_r, idle_nxt;

  logic [IDLE_BITS-1:0]  idle_inc;
  logic                  timed_out;
  logic                  is_delim;
  logic                  alnum;
  logic [INDEX_BITS-1:0] prop_inc;
  logic [7:0]            shown_idx;

  assign idle_inc  = (idle_r == IDLE_MAX) ? idle_r : idle_r + 1'b1;
  assign timed_out = idle_inc > IDLE_BITS'(cfg.timeout_ticks);
  assign is_delim  = (data_byte == cfg.property_char) || (data_byte == cfg.end_char) ||
                     (data_byte == cfg.start_char);
  assign alnum     = is_alnum(data_byte);
  assign prop_inc  = (prop_r == IDX_MAX) ? prop_r : prop_r + 1'b1;
  assign shown_idx = (prop_r > INDEX_BITS'(255)) ? 8'd255 : 8'(prop_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    prop_nxt  = prop_r;
    idle_nxt  = idle_r;
    if (adv) begin
      if (opcode == OP_TICK) begin
        if (state_r == ST_TYPE || state_r == ST_PROP) begin
          idle_nxt = idle_inc;
          if (timed_out) begin
            state_nxt = ST_WAIT;
            prop_nxt  = '0;
            idle_nxt  = '0;
          end
        end
      end else begin
        idle_nxt = '0;
        unique case (state_r)
          ST_TYPE: begin
            if (!alnum) begin
              prop_nxt = '0;
              if (data_byte == cfg.property_char) state_nxt = ST_PROP;
              else if (data_byte == cfg.end_char) state_nxt = ST_WAIT;
              else if (data_byte == cfg.start_char) state_nxt = ST_TYPE;
              else state_nxt = ST_WAIT;
            end
          end
          ST_PROP: begin
            if (is_delim) begin
              prop_nxt = prop_inc;
              if (data_byte == cfg.property_char) state_nxt = ST_PROP;
              else if (data_byte == cfg.end_char) state_nxt = ST_WAIT;
              else state_nxt = ST_TYPE;
            end
          end
          ST_WAIT: begin
            state_nxt = (data_byte == cfg.start_char) ? ST_TYPE : ST_WAIT;
          end
          default: begin
            state_nxt = ST_WAIT;
          end
        endcase
      end
    end
  end

  // result requests
  always_comb begin
    push      = '0;
    push.res0 = '0;
    push.res1 = '0;
    if (adv) begin
      if (opcode == OP_TICK) begin
        if ((state_r == ST_TYPE || state_r == ST_PROP) && timed_out) begin
          push.cnt       = 2'd1;
          push.res0.ev   = EV_CANCEL;
          push.res0.last = 1'b1;
        end
      end else begin
        unique case (state_r)
          ST_TYPE: begin
            if (alnum) begin
              push.cnt             = 2'd1;
              push.res0.ev         = EV_TYPE_CHAR;
              push.res0.char_value = data_byte;
              push.res0.last       = 1'b1;
            end else begin
              push.res0.ev = EV_TYPE_DONE;
              if (data_byte == cfg.property_char) begin
                push.cnt       = 2'd1;
                push.res0.last = 1'b1;
              end else begin
                push.cnt       = 2'd2;
                push.res1.ev   = (data_byte == cfg.end_char) ? EV_COMPLETE : EV_CANCEL;
                push.res1.last = 1'b1;
              end
            end
          end
          ST_PROP: begin
            if (is_delim) begin
              push.res0.ev             = EV_PROP_DONE;
              push.res0.property_index = shown_idx;
              if (data_byte == cfg.property_char) begin
                push.cnt       = 2'd1;
                push.res0.last = 1'b1;
              end else begin
                push.cnt       = 2'd2;
                push.res1.ev   = (data_byte == cfg.end_char) ? EV_COMPLETE : EV_CANCEL;
                push.res1.last = 1'b1;
              end
            end else begin
              push.cnt             = 2'd1;
              push.res0.ev         = EV_PROP_CHAR;
              push.res0.char_value = data_byte;
              push.res0.last       = 1'b1;
            end
          end
          default: begin
            push.cnt = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      prop_r  <= '0;
      idle_r  <= '0;
    end else begin
      state_r <= state_nxt;
      prop_r  <= prop_nxt;
      idle_r  <= idle_nxt;
    end
  end

  a_two_starts_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.res0.ev == EV_TYPE_DONE || push.res0.ev == EV_PROP_DONE))
    else $error("two results not led by a done event");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && opcode == OP_TICK && push.cnt != 2'd0) |=>
    (state_r == ST_WAIT && prop_r == '0 && idle_r == '0))
    else $error("timeout did not clear parse state");

  a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && opcode == OP_BYTE) |=> (idle_r == '0))
    else $error("byte did not clear idle count");

endmodule

// ----- design/dmd_out_fifo.sv -----
module dmd_out_fifo import dmd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output logic    room,
  output logic    not_empty,
  output result_t head
);

  localparam int DEPTH = 4;

  result_t    mem_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 2'd1;
  assign room      = count_r <= 3'(DEPTH - 2);
  assign not_empty = count_r != 3'd0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(push.cnt) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.res0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("push without room");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

// ----- design/delimited_message_deframer.sv -----
// Message deframer: each request on the in_ channel is a received byte or one idle tick,
// and the out_ channel gives the parse events it causes (zero, one or two, the final one
// flagged by out_last). A request waits in the input register until the four-entry result
// queue has room, then its events are written into that queue, from which they are taken.
// One request is taken per cycle while each gives at most one event and out_stall is low;
// the single output port drains one event per cycle unless stalled; two events leave in turn.
// Configuration is accepted at any time (cfg_ready stays high) and should be written only
// while the block is idle.
module delimited_message_deframer import dmd_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_char_value,
  output logic [7:0]  out_property_index,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  logic       in_vld_r;
  logic       op_r;
  logic [7:0] byte_r;
  logic       adv;
  logic       room;
  logic       not_empty;
  logic       pop;
  push_t      push;
  result_t    head;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign pop       = not_empty && !out_stall;

  assign out_valid          = not_empty;
  assign out_event_res      = head.ev;
  assign out_char_value     = head.char_value;
  assign out_property_index = head.property_index;
  assign out_last           = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_char    <= 8'd60;
      cfg_r.end_char      <= 8'd62;
      cfg_r.property_char <= 8'd124;
      cfg_r.timeout_ticks <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_CHAR:    cfg_r.start_char    <= cfg_data[7:0];
        REG_END_CHAR:      cfg_r.end_char      <= cfg_data[7:0];
        REG_PROPERTY_CHAR: cfg_r.property_char <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r   <= in_opcode;
      byte_r <= in_data_byte;
    end
  end

  dmd_parser #(
    .INDEX_BITS(INDEX_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .opcode    (op_r),
    .data_byte (byte_r),
    .cfg       (cfg_r),
    .push      (push)
  );

  dmd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && !room))
    else $error("input stalled with queue room");

  a_reg_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (in_vld_r && $stable(op_r) && $stable(byte_r)))
    else $error("input register changed while stalled");

  a_output_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(head)))
    else $error("queue head changed while stalled");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb import dmd_pkg::*;;

  localparam int IDX_BITS = 8;
  localparam logic [IDX_BITS-1:0] IDX_TOP = {IDX_BITS{1'b1}};
  localparam logic [16:0] IDLE_TOP = 17'h1FFFF;

  localparam int CLOSE_END     = 0;
  localparam int CLOSE_RESTART = 1;
  localparam int CLOSE_STRAY   = 2;
  localparam int CLOSE_TIMEOUT = 3;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_BYTE;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_char_value;
  logic [7:0]  out_property_index;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_START_CHAR;
  logic [15:0] cfg_data = 16'd0;

  delimited_message_deframer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_char_value     (out_char_value),
    .out_property_index (out_property_index),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  rx_req_t        pending_reqs[$];
  result_t        expected_events[$];
  result_t        want;
  rx_req_t        next_req;
  cfg_t           cur_cfg;
  parse_state_t   frame_state;
  logic [IDX_BITS-1:0] prop_idx;
  logic [16:0]    idle_ticks;
  int             queued_cnt = 0;
  int             accepted_cnt = 0;
  int             error_cnt = 0;
  logic           req_taken = 1'b0;
  logic           cfg_taken = 1'b0;
  logic           idle_on = 1'b1;
  logic           big_hold_req = 1'b0;
  logic           big_hold_done = 1'b0;
  int             send_gap = 0;
  int             stall_left = 0;
  int             hold_left = 0;

  task automatic flag_error(input string msg);
    if (error_cnt < 200) $display("mismatch at %0t: %s", $time, msg);
    error_cnt++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic result_t make_event(input event_t ev, input logic [7:0] ch,
                                         input logic [7:0] idx);
    result_t r;
    r.ev = ev;
    r.char_value = ch;
    r.property_index = idx;
    r.last = 1'b0;
    return r;
  endfunction

  // expected events for one accepted request
  task automatic deframe_step(input logic op, input logic [7:0] c);
    result_t res[2];
    int      n;
    n = 0;
    if (op == OP_TICK) begin
      if (frame_state != ST_WAIT) begin
        if (idle_ticks < IDLE_TOP) idle_ticks++;
        if (idle_ticks > {1'b0, cur_cfg.timeout_ticks}) begin
          res[n++] = make_event(EV_CANCEL, 8'd0, 8'd0);
          frame_state = ST_WAIT;
          prop_idx = '0;
          idle_ticks = '0;
        end
      end
    end else begin
      idle_ticks = '0;
      case (frame_state)
        ST_TYPE: begin
          if (is_name_char(c)) begin
            res[n++] = make_event(EV_TYPE_CHAR, c, 8'd0);
          end else begin
            prop_idx = '0;
            res[n++] = make_event(EV_TYPE_DONE, 8'd0, 8'd0);
            if (c == cur_cfg.property_char) begin
              frame_state = ST_PROP;
            end else if (c == cur_cfg.end_char) begin
              res[n++] = make_event(EV_COMPLETE, 8'd0, 8'd0);
              frame_state = ST_WAIT;
            end else if (c == cur_cfg.start_char) begin
              res[n++] = make_event(EV_CANCEL, 8'd0, 8'd0);
              frame_state = ST_TYPE;
            end else begin
              res[n++] = make_event(EV_CANCEL, 8'd0, 8'd0);
              frame_state = ST_WAIT;
            end
          end
        end
        ST_PROP: begin
          if (c == cur_cfg.property_char || c == cur_cfg.end_char ||
              c == cur_cfg.start_char) begin
            res[n++] = make_event(EV_PROP_DONE, 8'd0,
                                  (prop_idx > 255) ? 8'd255 : 8'(prop_idx));
            if (prop_idx != IDX_TOP) prop_idx++;
            if (c == cur_cfg.property_char) begin
              frame_state = ST_PROP;
            end else if (c == cur_cfg.end_char) begin
              res[n++] = make_event(EV_COMPLETE, 8'd0, 8'd0);
              frame_state = ST_WAIT;
            end else begin
              res[n++] = make_event(EV_CANCEL, 8'd0, 8'd0);
              frame_state = ST_TYPE;
            end
          end else begin
            res[n++] = make_event(EV_PROP_CHAR, c, 8'd0);
          end
        end
        default: begin
          frame_state = (c == cur_cfg.start_char) ? ST_TYPE : ST_WAIT;
        end
      endcase
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) res[k].last = 1'b1;
      expected_events.push_back(res[k]);
    end
  endtask

  // monitor: config mirror, result check, prediction
  always @(posedge clk) begin
    req_taken <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst_n) begin
      cur_cfg = '{start_char: 8'd60, end_char: 8'd62, property_char: 8'd124,
                  timeout_ticks: 16'd1000};
      frame_state = ST_WAIT;
      prop_idx = '0;
      idle_ticks = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_CHAR:    cur_cfg.start_char = cfg_data[7:0];
          REG_END_CHAR:      cur_cfg.end_char = cfg_data[7:0];
          REG_PROPERTY_CHAR: cur_cfg.property_char = cfg_data[7:0];
          REG_TIMEOUT_TICKS: cur_cfg.timeout_ticks = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          flag_error($sformatf("unexpected event %0d", out_event_res));
        end else begin
          want = expected_events.pop_front();
          if (out_event_res != want.ev)
            flag_error($sformatf("event got %0d want %0d", out_event_res, want.ev));
          if (out_char_value != want.char_value)
            flag_error($sformatf("char got %0d want %0d", out_char_value,
                                 want.char_value));
          if (out_property_index != want.property_index)
            flag_error($sformatf("index got %0d want %0d", out_property_index,
                                 want.property_index));
          if (out_last != want.last)
            flag_error($sformatf("last got %0d want %0d", out_last, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        deframe_step(in_opcode, in_data_byte);
        accepted_cnt++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_req.op;
        in_data_byte <= next_req.data;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (big_hold_req && !big_hold_done) begin
      big_hold_done <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_req(input logic op, input logic [7:0] data);
    pending_reqs.push_back('{op: op, data: data});
    queued_cnt++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    push_req(OP_BYTE, c);
  endtask

  task automatic send_tick();
    push_req(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) send_tick();
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'(48 + r);
    if (r < 36) return 8'(65 + r - 10);
    return 8'(97 + r - 36);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == cur_cfg.start_char || c == cur_cfg.end_char ||
           c == cur_cfg.property_char;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_delim(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_stray();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_delim(c) || is_name_char(c));
    return c;
  endfunction

  task automatic send_message(input int type_len, input int n_props, input int close_kind);
    send_byte(cur_cfg.start_char);
    for (int k = 0; k < type_len; k++) begin
      send_byte(rand_alnum());
      maybe_ticks();
    end
    if (close_kind == CLOSE_STRAY) begin
      send_byte(pick_stray());
      return;
    end
    if (n_props > 0) send_byte(cur_cfg.property_char);
    for (int k = 0; k < n_props; k++) begin
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte(pick_plain());
        maybe_ticks();
      end
      if (k < n_props - 1) send_byte(cur_cfg.property_char);
    end
    case (close_kind)
      CLOSE_END:     send_byte(cur_cfg.end_char);
      CLOSE_RESTART: send_byte(cur_cfg.start_char);
      default: begin
        if (cur_cfg.timeout_ticks <= 16) repeat (cur_cfg.timeout_ticks + 1) send_tick();
        else repeat (3) send_tick();
      end
    endcase
  endtask

  task automatic random_traffic(input int n_items);
    int base;
    int r;
    base = queued_cnt;
    while (queued_cnt - base < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_message($urandom_range(0, 4), $urandom_range(0, 4), CLOSE_END);
      end else if (r < 88) begin
        send_message($urandom_range(0, 4), $urandom_range(0, 4),
                     $urandom_range(CLOSE_RESTART, CLOSE_TIMEOUT));
      end else begin
        repeat ($urandom_range(1, 5))
          push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_delims(input logic [7:0] s, input logic [7:0] e, input logic [7:0] p,
                            input logic [15:0] t);
    write_reg(REG_START_CHAR, {8'd0, s});
    write_reg(REG_END_CHAR, {8'd0, e});
    write_reg(REG_PROPERTY_CHAR, {8'd0, p});
    write_reg(REG_TIMEOUT_TICKS, t);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: ticks and noise while waiting, full message, restarts, stray
    send_tick();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte("<");
    send_byte("0"); send_byte("9"); send_byte("A"); send_byte("Z");
    send_byte("a"); send_byte("z");
    send_byte("|"); send_byte(8'h00); send_byte(8'hFF); send_byte("|");
    send_byte("x"); send_byte(">");
    send_byte("<"); send_byte("T"); send_byte("<");
    send_byte("|"); send_byte("v"); send_byte("<");
    send_byte("#");
    send_byte("<"); send_byte(">");
    random_traffic(100);
    big_hold_req = 1'b1;
    drain();

    // zero timeout and index saturation
    set_delims(8'h00, 8'hFF, 8'h80, 16'd0);
    send_byte(8'h00); send_tick();
    send_byte(8'h00); send_byte("a"); send_tick();
    send_byte(8'h00); send_byte("X");
    repeat (300) send_byte(8'h80);
    send_byte(8'hFF);
    random_traffic(100);
    drain();

    // alphanumeric property delimiter, no idling on either side
    idle_on = 1'b0;
    set_delims(8'hFF, 8'h00, "A", 16'd3);
    random_traffic(100);
    drain();

    idle_on = 1'b1;
    set_delims("#", 8'h0A, ";", 16'hFFFF);
    random_traffic(100);
    drain();

    // start and end share one byte
    set_delims("*", "*", "|", 16'd5);
    random_traffic(100);
    drain();

    set_delims(8'd60, 8'd62, 8'd124, 16'd1000);
    send_byte("<"); send_byte("a");
    repeat (1001) send_tick();
    random_traffic(100);
    drain();

    if (error_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
